// File: design/spwh_pkg.sv
// ----------------------------------------------------------------------------
// spwh_pkg
// Shared types and constants of the stepper position controller with homing.
// ----------------------------------------------------------------------------
package spwh_pkg;

    // default widths of the position and of the target fraction
    localparam int POSITION_BITS_DEF = 22;
    localparam int FRACTION_BITS_DEF = 16;

    // configuration register widths
    localparam int MAX_STEPS_W = 20;
    localparam int STEP_SIZE_W = 8;
    localparam int QUALIFY_W   = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    // scaled setpoint is below twice max_steps
    localparam int SETPOINT_W  = MAX_STEPS_W + 1;

    // switch qualification run counter
    localparam int RUN_W = 8;
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEPS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUALIFY_COUNT = 2'd2;

    // configuration reset values
    localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST     = '0;
    localparam logic [STEP_SIZE_W-1:0] STEP_SIZE_RST     = 8'd1;
    localparam logic [QUALIFY_W-1:0]   QUALIFY_COUNT_RST = 8'd10;

    // configuration register set
    typedef struct packed {
        logic [MAX_STEPS_W-1:0] max_steps;
        logic [STEP_SIZE_W-1:0] step_size;
        logic [QUALIFY_W-1:0]   qualify_count;
    } t_cfg;

    // tick as held in the input stage, target already scaled
    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint;
        logic                  drive_enable;
        logic                  homing_request;
        logic                  switch_level;
    } t_tick;

endpackage

// File: design/spwh_in_if.sv
// ----------------------------------------------------------------------------
// spwh_in_if
// Tick channel: target fraction, enable, homing request and switch sample.
// ----------------------------------------------------------------------------
interface spwh_in_if #(
    parameter int FRACTION_BITS = spwh_pkg::FRACTION_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [FRACTION_BITS:0] target_fraction;
    logic                   drive_enable;
    logic                   homing_request;
    logic                   switch_level;

    modport source (
        output valid, target_fraction, drive_enable, homing_request, switch_level,
        input  ready
    );

    modport sink (
        input  valid, target_fraction, drive_enable, homing_request, switch_level,
        output ready
    );
endinterface

// File: design/spwh_out_if.sv
// ----------------------------------------------------------------------------
// spwh_out_if
// Result channel: step pin levels, position, error and switch status.
// ----------------------------------------------------------------------------
interface spwh_out_if #(
    parameter int POSITION_BITS = spwh_pkg::POSITION_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic                            step_pulse;
    logic                            direction_left;
    logic                            driver_on;
    logic signed [POSITION_BITS-1:0] position_now;
    logic signed [POSITION_BITS-1:0] error_left;
    logic                            limit_hit;
    logic                            homing_done;

    modport source (
        output valid, step_pulse, direction_left, driver_on, position_now,
               error_left, limit_hit, homing_done,
        input  ready
    );

    modport sink (
        input  valid, step_pulse, direction_left, driver_on, position_now,
               error_left, limit_hit, homing_done,
        output ready
    );
endinterface

// File: design/spwh_cfg.sv
// ----------------------------------------------------------------------------
// spwh_cfg
// Configuration registers: max_steps, step_size and qualify_count.
// ----------------------------------------------------------------------------
module spwh_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spwh_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [spwh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output spwh_pkg::t_cfg                      o_cfg
);
    spwh_pkg::t_cfg r_cfg;
    spwh_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                spwh_pkg::REG_MAX_STEPS: begin
                    n_cfg.max_steps = i_cfg_data[spwh_pkg::MAX_STEPS_W-1:0];
                end
                spwh_pkg::REG_STEP_SIZE: begin
                    n_cfg.step_size = i_cfg_data[spwh_pkg::STEP_SIZE_W-1:0];
                end
                spwh_pkg::REG_QUALIFY_COUNT: begin
                    n_cfg.qualify_count = i_cfg_data[spwh_pkg::QUALIFY_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_steps     <= spwh_pkg::MAX_STEPS_RST;
            r_cfg.step_size     <= spwh_pkg::STEP_SIZE_RST;
            r_cfg.qualify_count <= spwh_pkg::QUALIFY_COUNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: design/spwh_scale.sv
// ----------------------------------------------------------------------------
// spwh_scale
// Input stage: accepts a tick and registers it with the target scaled to
// steps (target_fraction * max_steps, fraction bits dropped).
// ----------------------------------------------------------------------------
module spwh_scale #(
    parameter int FRACTION_BITS = spwh_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [spwh_pkg::MAX_STEPS_W-1:0]      i_max_steps,
    spwh_in_if.sink                               i_in,
    input  logic                                  i_take,
    output logic                                  o_tick_valid,
    output spwh_pkg::t_tick                       o_tick
);
    localparam int PROD_W = FRACTION_BITS + 1 + spwh_pkg::MAX_STEPS_W;

    logic                  r_valid;
    logic                  n_valid;
    spwh_pkg::t_tick       r_tick;
    logic [PROD_W-1:0]     product;
    logic                  in_acc;

    // stage is free when empty or when its tick moves on this cycle
    assign i_in.ready = !r_valid || i_take;
    assign in_acc     = i_in.valid && i_in.ready;

    // scale the fraction of travel to a step count
    assign product = PROD_W'(i_in.target_fraction) * PROD_W'(i_max_steps);

    always_comb begin
        if (in_acc) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // tick payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tick.setpoint       <= product[PROD_W-1:FRACTION_BITS];
            r_tick.drive_enable   <= i_in.drive_enable;
            r_tick.homing_request <= i_in.homing_request;
            r_tick.switch_level   <= i_in.switch_level;
        end
    end

    assign o_tick_valid = r_valid;
    assign o_tick       = r_tick;
endmodule

// File: design/spwh_core.sv
// ----------------------------------------------------------------------------
// spwh_core
// Controller state update and result register: switch qualification,
// homing, error forming, step issue and position saturation.
// ----------------------------------------------------------------------------
module spwh_core #(
    parameter int POSITION_BITS = spwh_pkg::POSITION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spwh_pkg::t_cfg  i_cfg,
    input  logic            i_tick_valid,
    input  spwh_pkg::t_tick i_tick,
    output logic            o_take,
    spwh_out_if.source      o_out
);
    localparam int PB = POSITION_BITS;
    localparam int SW = spwh_pkg::SETPOINT_W;
    localparam int CW = ((PB > SW) ? PB : SW) + 3;

    localparam logic signed [CW-1:0] POS_MAX = {{(CW-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [CW-1:0] POS_MIN = {{(CW-PB+1){1'b1}}, {(PB-1){1'b0}}};

    // clamp a wide value to the position range
    function automatic logic signed [PB-1:0] sat(input logic signed [CW-1:0] v);
        logic signed [PB-1:0] res;
        if (v > POS_MAX) begin
            res = POS_MAX[PB-1:0];
        end else if (v < POS_MIN) begin
            res = POS_MIN[PB-1:0];
        end else begin
            res = v[PB-1:0];
        end
        return res;
    endfunction

    // sign extend a position-wide value
    function automatic logic signed [CW-1:0] ext(input logic signed [PB-1:0] v);
        logic signed [CW-1:0] res;
        res = {{(CW-PB){v[PB-1]}}, v};
        return res;
    endfunction

    // controller state
    logic signed [PB-1:0]             r_pos;
    logic signed [PB-1:0]             r_err;
    logic                             r_dir;
    logic                             r_en;
    logic [spwh_pkg::RUN_W-1:0]       r_run;
    logic                             r_last;
    logic                             r_qual;

    // result register
    logic                             r_out_valid;
    logic                             r_pulse;
    logic                             r_done;

    // next values
    logic signed [PB-1:0]             n_pos;
    logic signed [PB-1:0]             n_err;
    logic                             n_dir;
    logic                             n_en;
    logic [spwh_pkg::RUN_W-1:0]       n_run;
    logic                             n_qual;
    logic                             n_pulse;
    logic                             n_done;

    // intermediates
    logic                             fire;
    logic signed [CW-1:0]             sp_w;
    logic signed [CW-1:0]             ms_w;
    logic signed [CW-1:0]             ss_w;
    logic signed [CW-1:0]             sp_diff;
    logic signed [CW-1:0]             sp_clamped;
    logic signed [PB-1:0]             pos0;
    logic signed [PB-1:0]             err0;

    // result register frees up when empty or taken
    assign o_take = !r_out_valid || o_out.ready;
    assign fire   = i_tick_valid && o_take;

    assign sp_w = {{(CW-SW){1'b0}}, i_tick.setpoint};
    assign ms_w = {{(CW-spwh_pkg::MAX_STEPS_W){1'b0}}, i_cfg.max_steps};
    assign ss_w = {{(CW-spwh_pkg::STEP_SIZE_W){1'b0}}, i_cfg.step_size};

    // switch qualification over consecutive samples
    always_comb begin
        if (i_tick.switch_level == r_last) begin
            n_run = (r_run == spwh_pkg::RUN_MAX) ? r_run : r_run + 1'b1;
        end else begin
            n_run = '0;
        end
        n_qual = (n_run >= i_cfg.qualify_count) ? i_tick.switch_level : r_qual;
    end

    // error forming for homing and position ticks, then step issue
    always_comb begin
        n_done     = 1'b0;
        sp_diff    = sp_w - ext(r_pos);
        sp_clamped = (sp_w > ms_w) ? ms_w : sp_w;
        if (i_tick.homing_request) begin
            n_en = 1'b1;
            if (n_qual) begin
                pos0   = '0;
                err0   = '0;
                n_done = 1'b1;
            end else begin
                pos0 = r_pos;
                err0 = sat(-ss_w);
            end
        end else begin
            n_en = i_tick.drive_enable;
            // switch pressed while heading left re-zeroes the position
            if (n_qual && sp_diff[CW-1]) begin
                pos0 = '0;
            end else begin
                pos0 = r_pos;
            end
            err0 = sat(sp_clamped - ext(pos0));
        end

        n_pulse = n_en && (err0 != '0);
        if (n_pulse) begin
            n_dir = err0[PB-1];
            if (n_dir) begin
                n_pos = sat(ext(pos0) - ss_w);
                n_err = sat(ext(err0) + ss_w);
            end else begin
                n_pos = sat(ext(pos0) + ss_w);
                n_err = sat(ext(err0) - ss_w);
            end
        end else begin
            n_dir = r_dir;
            n_pos = pos0;
            n_err = err0;
        end
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_err       <= '0;
            r_dir       <= 1'b0;
            r_en        <= 1'b0;
            r_run       <= '0;
            r_last      <= 1'b0;
            r_qual      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= fire || (r_out_valid && !o_out.ready);
            if (fire) begin
                r_pos  <= n_pos;
                r_err  <= n_err;
                r_dir  <= n_dir;
                r_en   <= n_en;
                r_run  <= n_run;
                r_last <= i_tick.switch_level;
                r_qual <= n_qual;
            end
        end
    end

    // per-transaction flags
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pulse <= n_pulse;
            r_done  <= n_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.step_pulse     = r_pulse;
    assign o_out.direction_left = r_dir;
    assign o_out.driver_on      = r_en;
    assign o_out.position_now   = r_pos;
    assign o_out.error_left     = r_err;
    assign o_out.limit_hit      = r_qual;
    assign o_out.homing_done    = r_done;
endmodule

// File: design/stepper_position_with_homing.sv
// ----------------------------------------------------------------------------
// stepper_position_with_homing
// Step/direction position controller with limit-switch homing.
// ----------------------------------------------------------------------------
// One tick transaction is accepted per clock while results are taken, and each
// gives one result transaction: the first stage registers the tick and scales the target
// fraction by max_steps in one multiplier, the second updates the position,
// error and switch qualifier in one pass and loads the result register. That
// state loop closes within the second stage, which sets the rate
// at one transaction per clock. The input stays ready while a result waits,
// until both stages hold a transaction. The user writes configuration registers
// through the plain write port while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module stepper_position_with_homing #(
    parameter int POSITION_BITS = spwh_pkg::POSITION_BITS_DEF,
    parameter int FRACTION_BITS = spwh_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spwh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [spwh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    spwh_in_if.sink                          i_in,
    spwh_out_if.source                       o_out
);
    spwh_pkg::t_cfg  cfg;
    spwh_pkg::t_tick tick;
    logic            tick_valid;
    logic            take;

    // configuration registers
    spwh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register and target scaling
    spwh_scale #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_steps  (cfg.max_steps),
        .i_in         (i_in),
        .i_take       (take),
        .o_tick_valid (tick_valid),
        .o_tick       (tick)
    );

    // state update and result register
    spwh_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick_valid (tick_valid),
        .i_tick       (tick),
        .o_take       (take),
        .o_out        (o_out)
    );
endmodule

// File: dv/stepper_position_with_homing_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_with_homing_tb
// Self-checking bench for the stepper position controller with homing. Tick
// transactions come from a queue through a driver with random gaps, results
// are taken by a monitor with random stalls and checked field by field against
// a cycle-free motion predictor kept in step with the register settings.
// ----------------------------------------------------------------------------
module stepper_position_with_homing_tb;

    localparam int PB = spwh_pkg::POSITION_BITS_DEF;
    localparam int FB = spwh_pkg::FRACTION_BITS_DEF;
    localparam int MS_W = spwh_pkg::MAX_STEPS_W;
    localparam int SS_W = spwh_pkg::STEP_SIZE_W;
    localparam int QC_W = spwh_pkg::QUALIFY_W;
    localparam int FRAC_TOP = (1 << (FB + 1)) - 1;
    localparam int FRAC_FULL = 1 << FB;
    localparam longint POS_HI = (longint'(1) << (PB - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [FB:0] target_fraction;
        logic        drive_enable;
        logic        homing_request;
        logic        switch_level;
    } t_tick_item;

    typedef struct packed {
        logic                 step_pulse;
        logic                 direction_left;
        logic                 driver_on;
        logic signed [PB-1:0] position_now;
        logic signed [PB-1:0] error_left;
        logic                 limit_hit;
        logic                 homing_done;
    } t_motion;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [spwh_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [spwh_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    spwh_in_if  tick_if ();
    spwh_out_if res_if ();

    stepper_position_with_homing u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (tick_if),
        .o_out       (res_if)
    );

    // stimulus and scoreboard bookkeeping
    t_tick_item pending_ticks[$];
    t_motion    expected_moves[$];
    t_tick_item driven_tick;
    int      ticks_queued = 0;
    int      ticks_taken = 0;
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    logic    sw_now = 1'b0;

    // predictor copy of the registers
    logic [MS_W-1:0] cfg_max_steps = spwh_pkg::MAX_STEPS_RST;
    logic [SS_W-1:0] cfg_step_size = spwh_pkg::STEP_SIZE_RST;
    logic [QC_W-1:0] cfg_qualify   = spwh_pkg::QUALIFY_COUNT_RST;

    // predictor motion state
    longint pos;
    longint err;
    bit     dir_left;
    bit     drive_on;
    int     switch_run;
    bit     last_switch;
    bit     switch_ok;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // one pulse toward the remaining error, if the driver is on
    function automatic bit take_step();
        longint stride;
        stride = longint'(cfg_step_size);
        if (!drive_on || err == 0) return 1'b0;
        dir_left = (err < 0);
        if (dir_left) begin
            pos = clamp_pos(pos - stride);
            err = clamp_pos(err + stride);
        end else begin
            pos = clamp_pos(pos + stride);
            err = clamp_pos(err - stride);
        end
        return 1'b1;
    endfunction

    // advance the motion state by one tick and return the pin and position levels
    function automatic t_motion step_motor(input t_tick_item t);
        t_motion r;
        longint  setpoint;
        r = '0;
        // switch qualifier over consecutive ticks
        if (t.switch_level == last_switch) begin
            if (switch_run < int'(spwh_pkg::RUN_MAX)) switch_run++;
        end else begin
            switch_run = 0;
        end
        last_switch = t.switch_level;
        if (switch_run >= int'(cfg_qualify)) switch_ok = t.switch_level;

        if (t.homing_request) begin
            drive_on = 1'b1;
            if (switch_ok) begin
                pos = 0;
                err = 0;
                r.homing_done = 1'b1;
            end else begin
                err = clamp_pos(-longint'(cfg_step_size));
                r.step_pulse = take_step();
            end
        end else begin
            setpoint = (longint'(t.target_fraction) * longint'(cfg_max_steps)) >>> FB;
            // switch pressed while heading left re-zeroes before the error is formed
            if (switch_ok && setpoint - pos < 0) pos = 0;
            if (setpoint > longint'(cfg_max_steps)) setpoint = longint'(cfg_max_steps);
            err = clamp_pos(setpoint - pos);
            drive_on = t.drive_enable;
            r.step_pulse = take_step();
        end

        r.direction_left = dir_left;
        r.driver_on      = drive_on;
        r.position_now   = pos[PB-1:0];
        r.error_left     = err[PB-1:0];
        r.limit_hit      = switch_ok;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // tick driver: holds a transaction until taken, predicts on acceptance
    always @(posedge i_clk) begin : tick_driver
        t_tick_item nxt;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            pos         = 0;
            err         = 0;
            dir_left    = 1'b0;
            drive_on    = 1'b0;
            switch_run  = 0;
            last_switch = 1'b0;
            switch_ok   = 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                expected_moves.push_back(step_motor(driven_tick));
                ticks_taken++;
            end
            if (tick_if.valid && !tick_if.ready) begin
                // stalled, keep the transaction on the bus
            end else if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ticks.pop_front();
                driven_tick = nxt;
                tick_if.valid           <= 1'b1;
                tick_if.target_fraction <= nxt.target_fraction;
                tick_if.drive_enable    <= nxt.drive_enable;
                tick_if.homing_request  <= nxt.homing_request;
                tick_if.switch_level    <= nxt.switch_level;
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure and field compare
    always @(posedge i_clk) begin : result_monitor
        t_motion want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: result transaction with no tick pending", $time);
                    mismatches++;
                end else begin
                    want = expected_moves.pop_front();
                    check_field("step_pulse", 64'(want.step_pulse), 64'(res_if.step_pulse));
                    check_field("direction_left", 64'(want.direction_left),
                                64'(res_if.direction_left));
                    check_field("driver_on", 64'(want.driver_on), 64'(res_if.driver_on));
                    check_field("position_now", 64'(want.position_now),
                                64'(res_if.position_now));
                    check_field("error_left", 64'(want.error_left), 64'(res_if.error_left));
                    check_field("limit_hit", 64'(want.limit_hit), 64'(res_if.limit_hit));
                    check_field("homing_done", 64'(want.homing_done),
                                64'(res_if.homing_done));
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_tick(input logic [FB:0] frac, input logic en, input logic home,
                              input logic sw);
        t_tick_item t;
        t.target_fraction = frac;
        t.drive_enable    = en;
        t.homing_request  = home;
        t.switch_level    = sw;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // wait until every tick is taken and every result checked
    task automatic wait_drained();
        while (ticks_taken != ticks_queued || expected_moves.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [MS_W-1:0] ms, input logic [SS_W-1:0] ss,
                             input logic [QC_W-1:0] qc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= spwh_pkg::REG_MAX_STEPS;
        i_cfg_data  <= spwh_pkg::CFG_DATA_W'(ms);
        @(posedge i_clk);
        i_cfg_index <= spwh_pkg::REG_STEP_SIZE;
        i_cfg_data  <= spwh_pkg::CFG_DATA_W'(ss);
        @(posedge i_clk);
        i_cfg_index <= spwh_pkg::REG_QUALIFY_COUNT;
        i_cfg_data  <= spwh_pkg::CFG_DATA_W'(qc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_max_steps = ms;
        cfg_step_size = ss;
        cfg_qualify   = qc;
    endtask

    function automatic logic [FB:0] pick_fraction();
        case ($urandom_range(7))
            0:       return '0;
            1:       return (FB + 1)'(FRAC_FULL);
            2:       return (FB + 1)'($urandom_range(FRAC_TOP));
            3:       return (FB + 1)'($urandom_range(64));
            default: return (FB + 1)'($urandom_range(FRAC_FULL));
        endcase
    endfunction

    // mostly homing runs and held targets, some single noise ticks
    task automatic random_ticks(input int count);
        int          made;
        int          len;
        int          mode;
        logic [FB:0] frac;
        made = 0;
        while (made < count) begin
            mode = $urandom_range(9);
            if (mode < 3) begin
                // travel left released, then pressed until qualified (sometimes cut short)
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    queue_tick(pick_fraction(), 1'($urandom_range(1)), 1'b1, 1'b0);
                end
                made += len;
                sw_now = 1'b1;
                len = int'(cfg_qualify) + $urandom_range(1, 3);
                if ($urandom_range(4) == 0) len = $urandom_range(1, len);
                for (int i = 0; i < len; i++) begin
                    queue_tick(pick_fraction(), 1'($urandom_range(1)), 1'b1, 1'b1);
                end
                made += len;
            end else if (mode < 9) begin
                // held target with occasional switch bounce and driver off
                frac = pick_fraction();
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(15) == 0) sw_now = ~sw_now;
                    queue_tick(frac, $urandom_range(9) != 0, 1'b0, sw_now);
                end
                made += len;
            end else begin
                queue_tick((FB + 1)'($urandom_range(FRAC_TOP)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    // run limit
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_index             = spwh_pkg::REG_MAX_STEPS;
        i_cfg_data              = '0;
        tick_if.valid           = 1'b0;
        tick_if.target_fraction = '0;
        tick_if.drive_enable    = 1'b0;
        tick_if.homing_request  = 1'b0;
        tick_if.switch_level    = 1'b0;
        res_if.ready            = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        queue_tick('0, 1'b1, 1'b0, 1'b0);
        queue_tick((FB + 1)'(FRAC_FULL), 1'b1, 1'b0, 1'b0);
        queue_tick('0, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // clamp, driver off, homing found after short qualification, left re-zero
        configure(20'd1000, 8'd3, 8'd2);
        queue_tick('0, 1'b1, 1'b0, 1'b0);
        queue_tick((FB + 1)'(FRAC_FULL), 1'b1, 1'b0, 1'b0);
        queue_tick((FB + 1)'(FRAC_TOP), 1'b1, 1'b0, 1'b0);
        queue_tick((FB + 1)'(FRAC_FULL), 1'b0, 1'b0, 1'b0);
        queue_tick((FB + 1)'(FRAC_FULL / 2), 1'b1, 1'b0, 1'b0);
        repeat (2) queue_tick('0, 1'b0, 1'b1, 1'b0);
        repeat (3) queue_tick('0, 1'b0, 1'b1, 1'b1);
        queue_tick((FB + 1)'(FRAC_FULL), 1'b1, 1'b0, 1'b1);
        queue_tick('0, 1'b1, 1'b0, 1'b1);
        repeat (3) queue_tick('0, 1'b1, 1'b0, 1'b0);
        wait_drained();

        // zero step size and immediate qualification, largest max_steps
        configure(20'hFFFFF, 8'd0, 8'd0);
        queue_tick((FB + 1)'(FRAC_FULL), 1'b1, 1'b0, 1'b1);
        queue_tick('0, 1'b0, 1'b1, 1'b0);
        queue_tick((FB + 1)'(FRAC_TOP), 1'b1, 1'b0, 1'b0);
        queue_tick((FB + 1)'(1), 1'b1, 1'b0, 1'b1);
        wait_drained();

        // long homing run: big steps left, then the run counter saturates
        configure(20'd0, 8'd255, 8'd255);
        repeat (12) queue_tick(pick_fraction(), 1'($urandom_range(1)), 1'b1, 1'b0);
        repeat (6) queue_tick(pick_fraction(), 1'b1, 1'b0, 1'b0);
        repeat (260) queue_tick('0, 1'b0, 1'b1, 1'b1);
        sw_now = 1'b1;
        wait_drained();

        // random phases under changing gaps and settings
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 21 : (p == 1) ? 88 : 0;
            recv_idle_pct = (p == 0) ? 88 : (p == 1) ? 21 : 0;
            for (int s = 0; s < 2; s++) begin
                wait_drained();
                case (2 * p + s)
                    0: configure(20'hFFFFF, 8'd255, 8'd1);
                    1: configure(MS_W'($urandom_range(5000)), SS_W'($urandom_range(1, 8)),
                                 QC_W'($urandom_range(1, 15)));
                    2: configure(20'd0, SS_W'($urandom_range(1, 255)),
                                 QC_W'($urandom_range(1, 12)));
                    3: configure(MS_W'($urandom_range(20'hFFFFF)),
                                 SS_W'($urandom_range(1, 255)),
                                 QC_W'($urandom_range(1, 20)));
                    4: configure(MS_W'($urandom_range(100, 100000)),
                                 SS_W'($urandom_range(1, 255)),
                                 QC_W'($urandom_range(1, 16)));
                    default: configure(MS_W'($urandom_range(2000)), 8'd1,
                                       QC_W'($urandom_range(1, 6)));
                endcase
                random_ticks(20);
                // sender holds off until every result is back
                wait_drained();
                random_ticks(20);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
